@@ hdl/mbrl_pkg.sv @@
// Shared types and constants of the memory budget reservation ledger.
// Used by mbrl_alu, mbrl_table and memory_budget_reservation_ledger; no dependencies.
package mbrl_pkg;

    // Table and field sizes
    localparam int ENTRIES       = 16;
    localparam int BYTE_BITS     = 48;
    localparam int OWNER_BITS    = 16;
    localparam int ENTRY_BITS    = $clog2(ENTRIES);
    localparam int CNT_BITS      = $clog2(ENTRIES + 1);
    localparam int ALU_BITS      = BYTE_BITS + 1;
    localparam int CMD_BITS      = 3;
    localparam int SLOT_BITS     = 4;
    localparam int STATUS_BITS   = 3;
    localparam int COUNT_OUT_BITS = 5;
    localparam int DENIAL_BITS   = 32;

    // Command codes
    localparam logic [CMD_BITS-1:0] CMD_RESERVE   = 3'd0;
    localparam logic [CMD_BITS-1:0] CMD_RELEASE   = 3'd1;
    localparam logic [CMD_BITS-1:0] CMD_RETAIN    = 3'd2;
    localparam logic [CMD_BITS-1:0] CMD_LEASE_REL = 3'd3;
    localparam logic [CMD_BITS-1:0] CMD_OWNER_REL = 3'd4;
    localparam logic [CMD_BITS-1:0] CMD_QUERY     = 3'd5;

    // Status codes
    localparam logic [STATUS_BITS-1:0] ST_OK      = 3'd0;
    localparam logic [STATUS_BITS-1:0] ST_INVALID = 3'd1;
    localparam logic [STATUS_BITS-1:0] ST_LIMIT   = 3'd2;
    localparam logic [STATUS_BITS-1:0] ST_UNKNOWN = 3'd3;
    localparam logic [STATUS_BITS-1:0] ST_FULL    = 3'd4;

    typedef struct packed {
        logic [CMD_BITS-1:0]   command;
        logic                  request_kind;
        logic [BYTE_BITS-1:0]  request_bytes;
        logic [OWNER_BITS-1:0] owner_tag;
        logic [SLOT_BITS-1:0]  slot_index;
    } t_req;

    typedef struct packed {
        logic [STATUS_BITS-1:0]    status;
        logic [SLOT_BITS-1:0]      granted_slot;
        logic                      done_res;
        logic                      hit_retained;
        logic [BYTE_BITS-1:0]      blocked_bytes;
        logic [COUNT_OUT_BITS-1:0] freed_count;
        logic [BYTE_BITS-1:0]      heap_total;
        logic [BYTE_BITS-1:0]      spill_total;
        logic [BYTE_BITS-1:0]      peak_total;
        logic [DENIAL_BITS-1:0]    denials;
        logic [COUNT_OUT_BITS-1:0] active_entries;
        logic                      lease_alive;
    } t_res;

    // One stored reservation
    typedef struct packed {
        logic                  kind;
        logic [BYTE_BITS-1:0]  bytes;
        logic [OWNER_BITS-1:0] owner;
    } t_slot;

    typedef enum logic {
        ALU_ADD,
        ALU_SUB
    } t_alu_op;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_RSV_SUM,
        S_RSV_REM,
        S_RSV_CMP,
        S_RSV_ADD,
        S_RSV_TOTAL,
        S_RSV_PEAK,
        S_SLOT_EXEC,
        S_OWN_SCAN,
        S_DONE
    } t_state;

endpackage

@@ hdl/mbrl_alu.sv @@
// Shared add/subtract unit of the ledger sequencer.
// Depends on mbrl_pkg; the top bit of the result is carry or borrow.
module mbrl_alu (
    input  mbrl_pkg::t_alu_op                i_op,
    input  logic [mbrl_pkg::ALU_BITS-1:0]    i_a,
    input  logic [mbrl_pkg::ALU_BITS-1:0]    i_b,
    output logic [mbrl_pkg::ALU_BITS:0]      o_y
);
    import mbrl_pkg::*;

    // Add or subtract one bit wider so the borrow lands on top
    always_comb begin
        if (i_op == ALU_SUB) begin
            o_y = {1'b0, i_a} - {1'b0, i_b};
        end else begin
            o_y = {1'b0, i_a} + {1'b0, i_b};
        end
    end

endmodule

@@ hdl/mbrl_table.sv @@
// Slot storage of the ledger: kind, bytes and owner of every reservation.
// Depends on mbrl_pkg; one write port and one registered read port.
module mbrl_table (
    input  logic                            i_clk,
    input  logic                            i_wr_en,
    input  logic [mbrl_pkg::ENTRY_BITS-1:0] i_wr_addr,
    input  mbrl_pkg::t_slot                 i_wr_entry,
    input  logic [mbrl_pkg::ENTRY_BITS-1:0] i_rd_addr,
    output mbrl_pkg::t_slot                 o_rd_entry
);
    import mbrl_pkg::*;

    t_slot r_mem [ENTRIES];
    t_slot r_rd;

    // Write a new reservation
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_entry;
        end
    end

    // Read one slot per cycle
    always_ff @(posedge i_clk) begin
        r_rd <= r_mem[i_rd_addr];
    end

    assign o_rd_entry = r_rd;

endmodule

@@ hdl/memory_budget_reservation_ledger.sv @@
// Top level of the memory budget reservation ledger: sequencer, flags and totals.
// Depends on mbrl_pkg, mbrl_alu and mbrl_table.
//
// Usage: drive a request on i_req and raise start while busy is low; the
// request is taken at that edge and busy stays high until the result is
// formed. The result appears on o_res for exactly one cycle with o_res_valid
// high; the receiver cannot stall it, so it must take it on that cycle.
// A new request may be started in the cycle the result strobe is high.
// The limit register is written through i_cfg_wr_en/i_cfg_wr_data; the user
// must write it only while idle, as the block itself does not enforce this.
// The sequencer drives one shared adder and a registered table read port.
// Retain, query, unknown slot, undefined command and invalid reserve go from
// dispatch straight to done; release and lease release pass through slot
// execution; a granted reserve passes through the sum, room, compare, add,
// total and peak states; owner release walks the slots, one slot per cycle
// through the read port. The next request may be accepted on the strobe cycle.
// Reset clears all slot flags, totals, peak, denial count and the limit;
// no clearing pass is needed since stored slots are read only while used.
module memory_budget_reservation_ledger (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           start,
    output logic                           busy,
    input  mbrl_pkg::t_req                 i_req,
    input  logic                           i_cfg_wr_en,
    input  logic [mbrl_pkg::BYTE_BITS-1:0] i_cfg_wr_data,
    output logic                           o_res_valid,
    output mbrl_pkg::t_res                 o_res
);
    import mbrl_pkg::*;

    // Control state
    t_state                   r_state, n_state;
    logic [ENTRIES-1:0]       r_used, n_used;
    logic [ENTRIES-1:0]       r_pinned, n_pinned;
    logic [ENTRIES-1:0]       r_live, n_live;
    logic [BYTE_BITS-1:0]     r_limit, n_limit;
    logic [BYTE_BITS-1:0]     r_heap, n_heap;
    logic [BYTE_BITS-1:0]     r_spill, n_spill;
    logic [BYTE_BITS-1:0]     r_peak, n_peak;
    logic [DENIAL_BITS-1:0]   r_denials, n_denials;
    logic [CNT_BITS-1:0]      r_active, n_active;
    logic                     r_res_valid, n_res_valid;

    // Working registers
    t_req                     r_req, n_req;
    logic [ALU_BITS-1:0]      r_acc, n_acc;
    logic [ALU_BITS-1:0]      r_rem, n_rem;
    logic [STATUS_BITS-1:0]   r_status, n_status;
    logic [ENTRY_BITS-1:0]    r_granted, n_granted;
    logic                     r_done, n_done;
    logic                     r_hit, n_hit;
    logic [BYTE_BITS-1:0]     r_blocked, n_blocked;
    logic [CNT_BITS-1:0]      r_released, n_released;
    logic [ENTRY_BITS:0]      r_scan, n_scan;
    logic [ENTRY_BITS-1:0]    r_eval_idx, n_eval_idx;
    logic                     r_eval_valid, n_eval_valid;
    t_res                     r_res, n_res;

    // Shared unit and table
    t_alu_op                  alu_op;
    logic [ALU_BITS-1:0]      alu_a;
    logic [ALU_BITS-1:0]      alu_b;
    logic [ALU_BITS:0]        alu_y;
    logic                     alu_borrow;
    logic                     tbl_we;
    t_slot                    tbl_wr_entry;
    logic [ENTRY_BITS-1:0]    tbl_rd_addr;
    t_slot                    tbl_rd;

    // Request decode
    logic [ENTRY_BITS-1:0]    slot_s;
    logic                     idx_ok;
    logic                     known;
    logic                     free_any;
    logic [ENTRY_BITS-1:0]    free_idx;
    logic                     owner_match;

    mbrl_alu u_alu (
        .i_op (alu_op),
        .i_a  (alu_a),
        .i_b  (alu_b),
        .o_y  (alu_y)
    );

    mbrl_table u_table (
        .i_clk      (i_clk),
        .i_wr_en    (tbl_we),
        .i_wr_addr  (free_idx),
        .i_wr_entry (tbl_wr_entry),
        .i_rd_addr  (tbl_rd_addr),
        .o_rd_entry (tbl_rd)
    );

    assign alu_borrow  = alu_y[ALU_BITS];
    assign slot_s      = ENTRY_BITS'(r_req.slot_index);
    assign idx_ok      = 32'(r_req.slot_index) < 32'(ENTRIES);
    assign known       = idx_ok && r_used[slot_s];
    assign owner_match = r_eval_valid && r_used[r_eval_idx]
                         && (tbl_rd.owner == r_req.owner_tag);
    assign busy        = (r_state != S_IDLE);
    assign o_res_valid = r_res_valid;
    assign o_res       = r_res;

    assign tbl_wr_entry = '{kind:  r_req.request_kind,
                            bytes: r_req.request_bytes,
                            owner: r_req.owner_tag};

    // Pick the lowest free slot
    always_comb begin
        free_any = 1'b0;
        free_idx = '0;
        for (int i = ENTRIES - 1; i >= 0; i--) begin
            if (!r_used[i]) begin
                free_any = 1'b1;
                free_idx = ENTRY_BITS'(i);
            end
        end
    end

    // Sequencer: next state, shared unit operands, flag and total updates
    always_comb begin
        n_state      = r_state;
        n_used       = r_used;
        n_pinned     = r_pinned;
        n_live       = r_live;
        n_limit      = r_limit;
        n_heap       = r_heap;
        n_spill      = r_spill;
        n_peak       = r_peak;
        n_denials    = r_denials;
        n_active     = r_active;
        n_res_valid  = 1'b0;
        n_req        = r_req;
        n_acc        = r_acc;
        n_rem        = r_rem;
        n_status     = r_status;
        n_granted    = r_granted;
        n_done       = r_done;
        n_hit        = r_hit;
        n_blocked    = r_blocked;
        n_released   = r_released;
        n_scan       = r_scan;
        n_eval_idx   = r_eval_idx;
        n_eval_valid = 1'b0;
        n_res        = r_res;
        alu_op       = ALU_ADD;
        alu_a        = '0;
        alu_b        = '0;
        tbl_we       = 1'b0;
        tbl_rd_addr  = (r_state == S_OWN_SCAN) ? r_scan[ENTRY_BITS-1:0] : slot_s;

        // Take a limit write
        if (i_cfg_wr_en) begin
            n_limit = i_cfg_wr_data;
        end

        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_req      = i_req;
                    n_status   = ST_OK;
                    n_granted  = '0;
                    n_done     = 1'b0;
                    n_hit      = 1'b0;
                    n_blocked  = '0;
                    n_released = '0;
                    n_state    = S_DISPATCH;
                end
            end

            S_DISPATCH: begin
                n_state = S_DONE;
                case (r_req.command)
                    CMD_RESERVE: begin
                        if (r_limit == '0 || r_req.request_bytes == '0
                            || r_req.owner_tag == '0) begin
                            n_status = ST_INVALID;
                            if (r_denials != '1) begin
                                n_denials = r_denials + 1'b1;
                            end
                        end else begin
                            n_state = S_RSV_SUM;
                        end
                    end
                    CMD_RELEASE: begin
                        if (!known) begin
                            n_status = ST_UNKNOWN;
                        end else begin
                            n_state = S_SLOT_EXEC;
                        end
                    end
                    CMD_RETAIN: begin
                        if (!known) begin
                            n_status = ST_UNKNOWN;
                        end else if (r_pinned[slot_s]) begin
                            n_status = ST_INVALID;
                        end else begin
                            n_pinned[slot_s] = 1'b1;
                            n_live[slot_s]   = 1'b1;
                        end
                    end
                    CMD_LEASE_REL: begin
                        if (!known) begin
                            n_status = ST_UNKNOWN;
                        end else if (r_pinned[slot_s]) begin
                            n_state = S_SLOT_EXEC;
                        end else begin
                            n_status = ST_INVALID;
                        end
                    end
                    CMD_OWNER_REL: begin
                        if (r_req.owner_tag == '0) begin
                            n_status = ST_INVALID;
                        end else begin
                            n_scan  = '0;
                            n_state = S_OWN_SCAN;
                        end
                    end
                    CMD_QUERY: begin
                        n_status = ST_OK;
                    end
                    default: begin
                        n_status = ST_INVALID;
                    end
                endcase
            end

            // Current combined total
            S_RSV_SUM: begin
                alu_a   = {1'b0, r_heap};
                alu_b   = {1'b0, r_spill};
                n_acc   = alu_y[ALU_BITS-1:0];
                n_state = S_RSV_REM;
            end

            // Room left under the limit
            S_RSV_REM: begin
                alu_op = ALU_SUB;
                alu_a  = {1'b0, r_limit};
                alu_b  = {1'b0, r_req.request_bytes};
                n_rem  = alu_y[ALU_BITS-1:0];
                if (alu_borrow) begin
                    n_status = ST_LIMIT;
                    if (r_denials != '1) begin
                        n_denials = r_denials + 1'b1;
                    end
                    n_state = S_DONE;
                end else begin
                    n_state = S_RSV_CMP;
                end
            end

            // Check the total against the room, then allocate
            S_RSV_CMP: begin
                alu_op  = ALU_SUB;
                alu_a   = r_rem;
                alu_b   = r_acc;
                n_state = S_DONE;
                if (alu_borrow) begin
                    n_status = ST_LIMIT;
                    if (r_denials != '1) begin
                        n_denials = r_denials + 1'b1;
                    end
                end else if (!free_any) begin
                    n_status = ST_FULL;
                end else begin
                    tbl_we             = 1'b1;
                    n_granted          = free_idx;
                    n_used[free_idx]   = 1'b1;
                    n_pinned[free_idx] = 1'b0;
                    n_live[free_idx]   = 1'b0;
                    n_active           = r_active + 1'b1;
                    n_done             = 1'b1;
                    n_state            = S_RSV_ADD;
                end
            end

            // Add the bytes to the sum of their kind
            S_RSV_ADD: begin
                alu_a = {1'b0, (r_req.request_kind ? r_spill : r_heap)};
                alu_b = {1'b0, r_req.request_bytes};
                if (r_req.request_kind) begin
                    n_spill = alu_y[BYTE_BITS-1:0];
                end else begin
                    n_heap = alu_y[BYTE_BITS-1:0];
                end
                n_state = S_RSV_TOTAL;
            end

            // New combined total, wrapped to the byte width
            S_RSV_TOTAL: begin
                alu_a   = {1'b0, r_heap};
                alu_b   = {1'b0, r_spill};
                n_acc   = {1'b0, alu_y[BYTE_BITS-1:0]};
                n_state = S_RSV_PEAK;
            end

            // Raise the peak
            S_RSV_PEAK: begin
                alu_op = ALU_SUB;
                alu_a  = {1'b0, r_peak};
                alu_b  = r_acc;
                if (alu_borrow) begin
                    n_peak = r_acc[BYTE_BITS-1:0];
                end
                n_state = S_DONE;
            end

            // Release or lease release with the slot read back
            S_SLOT_EXEC: begin
                alu_op  = ALU_SUB;
                alu_a   = {1'b0, (tbl_rd.kind ? r_spill : r_heap)};
                alu_b   = {1'b0, tbl_rd.bytes};
                n_state = S_DONE;
                if (r_req.command == CMD_RELEASE && r_pinned[slot_s]) begin
                    n_status       = ST_INVALID;
                    n_hit          = 1'b1;
                    n_blocked      = tbl_rd.bytes;
                    n_live[slot_s] = 1'b0;
                end else begin
                    if (tbl_rd.kind) begin
                        n_spill = alu_y[BYTE_BITS-1:0];
                    end else begin
                        n_heap = alu_y[BYTE_BITS-1:0];
                    end
                    n_used[slot_s]   = 1'b0;
                    n_pinned[slot_s] = 1'b0;
                    n_live[slot_s]   = 1'b0;
                    n_active         = r_active - 1'b1;
                    n_done           = 1'b1;
                end
            end

            // Walk the slots: issue one read, evaluate the previous one
            S_OWN_SCAN: begin
                if (32'(r_scan) < 32'(ENTRIES)) begin
                    n_eval_valid = 1'b1;
                    n_eval_idx   = r_scan[ENTRY_BITS-1:0];
                    n_scan       = r_scan + 1'b1;
                end
                if (owner_match && r_pinned[r_eval_idx]) begin
                    alu_a              = {1'b0, r_blocked};
                    alu_b              = {1'b0, tbl_rd.bytes};
                    n_blocked          = alu_y[BYTE_BITS-1:0];
                    n_hit              = 1'b1;
                    n_live[r_eval_idx] = 1'b0;
                end else if (owner_match) begin
                    alu_op = ALU_SUB;
                    alu_a  = {1'b0, (tbl_rd.kind ? r_spill : r_heap)};
                    alu_b  = {1'b0, tbl_rd.bytes};
                    if (tbl_rd.kind) begin
                        n_spill = alu_y[BYTE_BITS-1:0];
                    end else begin
                        n_heap = alu_y[BYTE_BITS-1:0];
                    end
                    n_used[r_eval_idx]   = 1'b0;
                    n_pinned[r_eval_idx] = 1'b0;
                    n_live[r_eval_idx]   = 1'b0;
                    n_active             = r_active - 1'b1;
                    n_released           = r_released + 1'b1;
                end
                if (r_eval_valid && 32'(r_eval_idx) == 32'(ENTRIES - 1)) begin
                    n_state = S_DONE;
                end
            end

            // Form the result
            S_DONE: begin
                n_res.status       = r_status;
                n_res.done_res     = r_done;
                if (r_req.command == CMD_OWNER_REL && r_req.owner_tag != '0) begin
                    n_res.status   = r_hit ? ST_INVALID : ST_OK;
                    n_res.done_res = (r_released != '0);
                end
                n_res.granted_slot   = SLOT_BITS'(r_granted);
                n_res.hit_retained   = r_hit;
                n_res.blocked_bytes  = r_blocked;
                n_res.freed_count    = COUNT_OUT_BITS'(r_released);
                n_res.heap_total     = r_heap;
                n_res.spill_total    = r_spill;
                n_res.peak_total     = r_peak;
                n_res.denials        = r_denials;
                n_res.active_entries = COUNT_OUT_BITS'(r_active);
                n_res.lease_alive    = idx_ok && r_live[slot_s]
                                       && (r_req.command == CMD_RELEASE
                                           || r_req.command == CMD_RETAIN
                                           || r_req.command == CMD_LEASE_REL
                                           || r_req.command == CMD_QUERY);
                n_res_valid = 1'b1;
                n_state     = S_IDLE;
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Hold control state, cleared by reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_used      <= '0;
            r_pinned    <= '0;
            r_live      <= '0;
            r_limit     <= '0;
            r_heap      <= '0;
            r_spill     <= '0;
            r_peak      <= '0;
            r_denials   <= '0;
            r_active    <= '0;
            r_res_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_used      <= n_used;
            r_pinned    <= n_pinned;
            r_live      <= n_live;
            r_limit     <= n_limit;
            r_heap      <= n_heap;
            r_spill     <= n_spill;
            r_peak      <= n_peak;
            r_denials   <= n_denials;
            r_active    <= n_active;
            r_res_valid <= n_res_valid;
        end
    end

    // Advance working registers
    always_ff @(posedge i_clk) begin
        r_req        <= n_req;
        r_acc        <= n_acc;
        r_rem        <= n_rem;
        r_status     <= n_status;
        r_granted    <= n_granted;
        r_done       <= n_done;
        r_hit        <= n_hit;
        r_blocked    <= n_blocked;
        r_released   <= n_released;
        r_scan       <= n_scan;
        r_eval_idx   <= n_eval_idx;
        r_eval_valid <= n_eval_valid;
        r_res        <= n_res;
    end

endmodule

@@ bench/tb.sv @@
// Self-checking testbench for memory_budget_reservation_ledger.
// Drives directed and random reserve/release/retain/lease/owner requests and predicts
// each result in a behavioral ledger; depends on mbrl_pkg and the ledger RTL only.
module tb;
    import mbrl_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_PERIOD   = 4;
    localparam int RESET_CYCLES = 9;
    localparam int TIMEOUT_NS   = 2_000_000;
    localparam int DRAIN_CYCLES = 40;
    localparam int PHASES       = 9;
    localparam int PHASE_ITEMS  = 190;

    // Command codes the block treats as undefined
    localparam logic [CMD_BITS-1:0] CMD_UNDEF_LO = 3'd6;
    localparam logic [CMD_BITS-1:0] CMD_UNDEF_HI = 3'd7;

    localparam logic [BYTE_BITS-1:0] BYTES_MAX = '1;

    typedef enum logic [1:0] {
        OP_REQUEST,
        OP_LIMIT,
        OP_DRAIN
    } t_op_kind;

    typedef struct {
        t_op_kind             op;
        t_req                 req;
        logic [BYTE_BITS-1:0] limit;
    } t_pending;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 start = 1'b0;
    logic                 busy;
    t_req                 ledger_req = '0;
    logic                 i_cfg_wr_en = 1'b0;
    logic [BYTE_BITS-1:0] i_cfg_wr_data = '0;
    logic                 o_res_valid;
    t_res                 o_res;

    // Stimulus and scoreboard storage
    t_pending pend_q[$];
    t_res     outcome_q[$];
    int       in_flight;
    int       burst_left;
    int       gap_left;
    int       mismatch_count;
    int       result_seq;

    // Behavioral copy of the ledger
    logic                  rsv_used   [ENTRIES];
    logic                  rsv_pinned [ENTRIES];
    logic                  rsv_lease  [ENTRIES];
    logic                  rsv_kind   [ENTRIES];
    logic [BYTE_BITS-1:0]  rsv_bytes  [ENTRIES];
    logic [OWNER_BITS-1:0] rsv_owner  [ENTRIES];
    logic [BYTE_BITS-1:0]  heap_sum;
    logic [BYTE_BITS-1:0]  spill_sum;
    logic [BYTE_BITS-1:0]  peak_sum;
    logic [DENIAL_BITS-1:0] denial_sum;
    logic [BYTE_BITS-1:0]  budget_limit;

    memory_budget_reservation_ledger DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_req         (ledger_req),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .o_res_valid   (o_res_valid),
        .o_res         (o_res)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // ---------------------------------------------------------------
    // Ledger prediction
    // ---------------------------------------------------------------

    function automatic void ledger_clear();
        for (int i = 0; i < ENTRIES; i++) begin
            rsv_used[i]   = 1'b0;
            rsv_pinned[i] = 1'b0;
            rsv_lease[i]  = 1'b0;
            rsv_kind[i]   = 1'b0;
            rsv_bytes[i]  = '0;
            rsv_owner[i]  = '0;
        end
        heap_sum     = '0;
        spill_sum    = '0;
        peak_sum     = '0;
        denial_sum   = '0;
        budget_limit = '0;
    endfunction

    // Return a slot's bytes to its kind's total and clear its flags
    function automatic void free_entry(int s);
        if (rsv_kind[s])
            spill_sum = spill_sum - rsv_bytes[s];
        else
            heap_sum = heap_sum - rsv_bytes[s];
        rsv_used[s]   = 1'b0;
        rsv_pinned[s] = 1'b0;
        rsv_lease[s]  = 1'b0;
    endfunction

    function automatic void count_denial();
        if (denial_sum != '1)
            denial_sum = denial_sum + 1'b1;
    endfunction

    // Apply one request to the ledger copy and return the result it should give
    function automatic t_res ledger_outcome(t_req rq);
        t_res             r;
        int               s;
        int               active;
        int               freed;
        logic             found;
        logic [BYTE_BITS:0] cur;
        r = '0;
        r.status = ST_OK;
        s = int'(rq.slot_index);
        freed = 0;
        case (rq.command)
            CMD_RESERVE: begin
                cur = {1'b0, heap_sum} + {1'b0, spill_sum};
                if (budget_limit == '0 || rq.request_bytes == '0 || rq.owner_tag == '0) begin
                    r.status = ST_INVALID;
                    count_denial();
                end else if (rq.request_bytes > budget_limit ||
                             cur > ({1'b0, budget_limit} - {1'b0, rq.request_bytes})) begin
                    r.status = ST_LIMIT;
                    count_denial();
                end else begin
                    // grant the lowest free slot
                    found = 1'b0;
                    for (int i = 0; i < ENTRIES; i++) begin
                        if (!found && !rsv_used[i]) begin
                            found = 1'b1;
                            r.granted_slot = SLOT_BITS'(i);
                        end
                    end
                    if (!found) begin
                        r.status = ST_FULL;
                    end else begin
                        s = int'(r.granted_slot);
                        rsv_used[s]   = 1'b1;
                        rsv_pinned[s] = 1'b0;
                        rsv_lease[s]  = 1'b0;
                        rsv_kind[s]   = rq.request_kind;
                        rsv_bytes[s]  = rq.request_bytes;
                        rsv_owner[s]  = rq.owner_tag;
                        if (rq.request_kind)
                            spill_sum = spill_sum + rq.request_bytes;
                        else
                            heap_sum = heap_sum + rq.request_bytes;
                        cur = {1'b0, heap_sum} + {1'b0, spill_sum};
                        if (cur > {1'b0, peak_sum})
                            peak_sum = cur[BYTE_BITS-1:0];
                        r.done_res = 1'b1;
                    end
                end
            end
            CMD_RELEASE: begin
                if (!rsv_used[s]) begin
                    r.status = ST_UNKNOWN;
                end else if (rsv_pinned[s]) begin
                    r.status        = ST_INVALID;
                    r.hit_retained  = 1'b1;
                    r.blocked_bytes = rsv_bytes[s];
                    rsv_lease[s]    = 1'b0;
                end else begin
                    free_entry(s);
                    r.done_res = 1'b1;
                end
            end
            CMD_RETAIN: begin
                if (!rsv_used[s]) begin
                    r.status = ST_UNKNOWN;
                end else if (rsv_pinned[s]) begin
                    r.status = ST_INVALID;
                end else begin
                    rsv_pinned[s] = 1'b1;
                    rsv_lease[s]  = 1'b1;
                end
            end
            CMD_LEASE_REL: begin
                if (!rsv_used[s]) begin
                    r.status = ST_UNKNOWN;
                end else if (rsv_pinned[s]) begin
                    free_entry(s);
                    r.done_res = 1'b1;
                end else begin
                    r.status = ST_INVALID;
                end
            end
            CMD_OWNER_REL: begin
                if (rq.owner_tag == '0) begin
                    r.status = ST_INVALID;
                end else begin
                    // free unpinned entries of this owner, hold pinned ones
                    for (int i = 0; i < ENTRIES; i++) begin
                        if (rsv_used[i] && rsv_owner[i] == rq.owner_tag) begin
                            if (rsv_pinned[i]) begin
                                r.hit_retained  = 1'b1;
                                r.blocked_bytes = r.blocked_bytes + rsv_bytes[i];
                                rsv_lease[i]    = 1'b0;
                            end else begin
                                free_entry(i);
                                freed++;
                            end
                        end
                    end
                    r.freed_count = COUNT_OUT_BITS'(freed);
                    r.done_res = (freed != 0);
                    if (r.hit_retained)
                        r.status = ST_INVALID;
                end
            end
            CMD_QUERY: begin
            end
            default: r.status = ST_INVALID;
        endcase

        if (rq.command == CMD_RELEASE || rq.command == CMD_RETAIN ||
            rq.command == CMD_LEASE_REL || rq.command == CMD_QUERY)
            r.lease_alive = rsv_lease[rq.slot_index];
        active = 0;
        for (int i = 0; i < ENTRIES; i++)
            active += int'(rsv_used[i]);
        r.active_entries = COUNT_OUT_BITS'(active);
        r.heap_total     = heap_sum;
        r.spill_total    = spill_sum;
        r.peak_total     = peak_sum;
        r.denials        = denial_sum;
        return r;
    endfunction

    // ---------------------------------------------------------------
    // Checking
    // ---------------------------------------------------------------

    // Print one line per mismatch and count it
    task automatic report_mismatch(string what);
        mismatch_count++;
        $display("[%0t] mismatch: %s", $realtime, what);
    endtask

    task automatic check_field(string field, logic [63:0] got, logic [63:0] want);
        if (got !== want)
            report_mismatch($sformatf("result %0d %s: got %0h, want %0h",
                                      result_seq, field, got, want));
    endtask

    task automatic check_result(t_res got, t_res want);
        check_field("status",         got.status,         want.status);
        check_field("granted_slot",   got.granted_slot,   want.granted_slot);
        check_field("done_res",       got.done_res,       want.done_res);
        check_field("hit_retained",   got.hit_retained,   want.hit_retained);
        check_field("blocked_bytes",  got.blocked_bytes,  want.blocked_bytes);
        check_field("freed_count",    got.freed_count,    want.freed_count);
        check_field("heap_total",     got.heap_total,     want.heap_total);
        check_field("spill_total",    got.spill_total,    want.spill_total);
        check_field("peak_total",     got.peak_total,     want.peak_total);
        check_field("denials",        got.denials,        want.denials);
        check_field("active_entries", got.active_entries, want.active_entries);
        check_field("lease_alive",    got.lease_alive,    want.lease_alive);
    endtask

    // Monitor: check the result strobe first, then track limit writes and
    // predict every request accepted at this edge
    always @(posedge i_clk) begin
        t_res want;
        if (!i_rst_n) begin
            ledger_clear();
            outcome_q.delete();
        end else begin
            if (o_res_valid) begin
                if (outcome_q.size() == 0) begin
                    report_mismatch($sformatf("result %0d arrived with no request pending",
                                              result_seq));
                end else begin
                    want = outcome_q.pop_front();
                    check_result(o_res, want);
                end
                result_seq++;
            end
            if (i_cfg_wr_en)
                budget_limit = i_cfg_wr_data;
            if (start && !busy)
                outcome_q.insert(outcome_q.size(), ledger_outcome(ledger_req));
        end
    end

    // ---------------------------------------------------------------
    // Driver
    // ---------------------------------------------------------------

    // Issue pending requests in bursts; limit writes and drain marks wait
    // until no request is in flight
    always @(posedge i_clk) begin
        logic                 taken;
        logic                 hold;
        logic                 start_n;
        logic                 wr_n;
        t_req                 req_n;
        logic [BYTE_BITS-1:0] wdata_n;
        if (!i_rst_n) begin
            start       <= 1'b0;
            i_cfg_wr_en <= 1'b0;
            in_flight   = 0;
            burst_left  = 0;
            gap_left    = 0;
        end else begin
            taken = start && !busy;
            if (o_res_valid)
                in_flight--;
            if (taken) begin
                in_flight++;
                pend_q.delete(0);
                // close the burst and draw the next gap and burst length
                if (burst_left > 0)
                    burst_left--;
                if (burst_left == 0) begin
                    burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(60, 120)
                                                             : $urandom_range(1, 30);
                    gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 24);
                end
            end

            hold    = start && !taken;
            start_n = hold;
            req_n   = ledger_req;
            wr_n    = 1'b0;
            wdata_n = i_cfg_wr_data;
            if (!hold) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (pend_q.size() != 0) begin
                    case (pend_q[0].op)
                        OP_REQUEST: begin
                            start_n = 1'b1;
                            req_n   = pend_q[0].req;
                        end
                        OP_LIMIT: begin
                            if (in_flight == 0) begin
                                wr_n    = 1'b1;
                                wdata_n = pend_q[0].limit;
                                pend_q.delete(0);
                            end
                        end
                        default: begin
                            if (in_flight == 0)
                                pend_q.delete(0);
                        end
                    endcase
                end
            end
            start         <= start_n;
            ledger_req    <= req_n;
            i_cfg_wr_en   <= wr_n;
            i_cfg_wr_data <= wdata_n;
        end
    end

    // ---------------------------------------------------------------
    // Stimulus
    // ---------------------------------------------------------------

    function automatic void queue_request(logic [CMD_BITS-1:0] cmd, logic kind,
                                          logic [BYTE_BITS-1:0] bytes,
                                          logic [OWNER_BITS-1:0] owner,
                                          logic [SLOT_BITS-1:0] slot);
        t_pending p;
        p.op                = OP_REQUEST;
        p.req.command       = cmd;
        p.req.request_kind  = kind;
        p.req.request_bytes = bytes;
        p.req.owner_tag     = owner;
        p.req.slot_index    = slot;
        p.limit             = '0;
        pend_q.insert(pend_q.size(), p);
    endfunction

    function automatic void queue_limit(logic [BYTE_BITS-1:0] value);
        t_pending p;
        p.op    = OP_LIMIT;
        p.req   = '0;
        p.limit = value;
        pend_q.insert(pend_q.size(), p);
    endfunction

    function automatic void queue_drain();
        t_pending p;
        p.op    = OP_DRAIN;
        p.req   = '0;
        p.limit = '0;
        pend_q.insert(pend_q.size(), p);
    endfunction

    function automatic logic [BYTE_BITS-1:0] rand_bytes48();
        logic [63:0] raw;
        raw = {$urandom, $urandom};
        return raw[BYTE_BITS-1:0];
    endfunction

    // Mostly amounts well inside the limit, plus zero, exact, over and wild sizes
    function automatic logic [BYTE_BITS-1:0] pick_bytes(logic [BYTE_BITS-1:0] lim);
        logic [63:0] span;
        logic [63:0] pick;
        int          sel;
        sel  = $urandom_range(0, 19);
        span = {16'd0, lim} / 6 + 1;
        pick = {16'd0, rand_bytes48()} % span + 1;
        if (sel < 13)
            return pick[BYTE_BITS-1:0];
        else if (sel == 13)
            return '0;
        else if (sel == 14)
            return lim;
        else if (sel < 17)
            return (lim == BYTES_MAX) ? BYTES_MAX : lim + 1'b1;
        else
            return rand_bytes48();
    endfunction

    // Small owner pool so owner releases hit several entries
    function automatic logic [OWNER_BITS-1:0] pick_owner();
        int sel;
        sel = $urandom_range(0, 19);
        if (sel < 15)
            return OWNER_BITS'($urandom_range(1, 4));
        else if (sel == 15)
            return '0;
        else if (sel == 16)
            return '1;
        else
            return OWNER_BITS'($urandom);
    endfunction

    function automatic logic [SLOT_BITS-1:0] pick_slot();
        if ($urandom_range(0, 1) == 0)
            return SLOT_BITS'($urandom_range(0, 7));
        return SLOT_BITS'($urandom_range(0, ENTRIES - 1));
    endfunction

    function automatic void queue_random_request(logic [BYTE_BITS-1:0] lim);
        int sel;
        logic [CMD_BITS-1:0] cmd;
        sel = $urandom_range(0, 99);
        if (sel < 40)      cmd = CMD_RESERVE;
        else if (sel < 52) cmd = CMD_RELEASE;
        else if (sel < 67) cmd = CMD_RETAIN;
        else if (sel < 77) cmd = CMD_LEASE_REL;
        else if (sel < 85) cmd = CMD_OWNER_REL;
        else if (sel < 97) cmd = CMD_QUERY;
        else if (sel < 99) cmd = CMD_UNDEF_LO;
        else               cmd = CMD_UNDEF_HI;
        queue_request(cmd, 1'($urandom_range(0, 1)), pick_bytes(lim), pick_owner(),
                      pick_slot());
    endfunction

    initial begin
        logic [BYTE_BITS-1:0] phase_limit [PHASES];
        logic [BYTE_BITS-1:0] lim;
        logic [BYTE_BITS-1:0] fill_bytes;
        int                   n_items;

        mismatch_count = 0;
        result_seq     = 0;

        // Directed: limit still zero after reset
        queue_request(CMD_RESERVE, 1'b0, 48'd100, 16'd1, 4'd0);
        queue_request(CMD_QUERY, 1'b0, '0, '0, 4'd15);
        queue_request(CMD_UNDEF_LO, 1'b0, '0, '0, 4'd0);
        queue_request(CMD_UNDEF_HI, 1'b1, BYTES_MAX, '1, 4'd15);

        // Directed: widest limit, invalid fields, exact fill, then over limit
        queue_limit(BYTES_MAX);
        queue_request(CMD_RESERVE, 1'b0, '0, 16'd1, 4'd0);
        queue_request(CMD_RESERVE, 1'b0, 48'd10, '0, 4'd0);
        queue_request(CMD_RESERVE, 1'b1, BYTES_MAX, '1, 4'd0);
        queue_request(CMD_RESERVE, 1'b0, 48'd1, 16'd2, 4'd0);
        // unknown slot for each slot command
        queue_request(CMD_RELEASE, 1'b0, '0, '0, 4'd5);
        queue_request(CMD_RETAIN, 1'b0, '0, '0, 4'd5);
        queue_request(CMD_LEASE_REL, 1'b0, '0, '0, 4'd5);
        // pin, pin again, release blocked by the pin, then query the dead lease
        queue_request(CMD_RETAIN, 1'b0, '0, '0, 4'd0);
        queue_request(CMD_RETAIN, 1'b0, '0, '0, 4'd0);
        queue_request(CMD_RELEASE, 1'b0, '0, '0, 4'd0);
        queue_request(CMD_QUERY, 1'b0, '0, '0, 4'd0);
        queue_request(CMD_OWNER_REL, 1'b0, '0, '1, 4'd0);
        queue_request(CMD_LEASE_REL, 1'b0, '0, '0, 4'd0);
        // lease release on an unpinned entry, owner zero, owner sweep, plain release
        queue_request(CMD_RESERVE, 1'b0, 48'd7, 16'd3, 4'd0);
        queue_request(CMD_LEASE_REL, 1'b0, '0, '0, 4'd0);
        queue_request(CMD_OWNER_REL, 1'b0, '0, '0, 4'd0);
        queue_request(CMD_OWNER_REL, 1'b0, '0, 16'd3, 4'd0);
        queue_request(CMD_RESERVE, 1'b0, 48'd9, 16'd5, 4'd0);
        queue_request(CMD_RELEASE, 1'b0, '0, '0, 4'd0);
        queue_drain();

        // Random phases, one limit setting each, extremes included
        phase_limit[0] = BYTES_MAX;
        phase_limit[1] = 48'd1000;
        phase_limit[2] = 48'd1;
        phase_limit[3] = rand_bytes48();
        phase_limit[4] = 48'h1_0000_0000;
        phase_limit[5] = 48'd64;
        phase_limit[6] = '0;
        phase_limit[7] = BYTES_MAX - 48'd1;
        phase_limit[8] = 48'd5000;
        for (int p = 0; p < PHASES; p++) begin
            lim = phase_limit[p];
            queue_limit(lim);
            // fill the table past its size to reach the full case
            fill_bytes = (lim / 20 == 0) ? 48'd1 : lim / 20;
            for (int k = 0; k < ENTRIES + 1; k++)
                queue_request(CMD_RESERVE, 1'($urandom_range(0, 1)), fill_bytes,
                              pick_owner(), '0);
            n_items = (lim == '0) ? 40 : PHASE_ITEMS;
            for (int k = 0; k < n_items; k++) begin
                if (k == n_items / 2)
                    queue_drain();
                queue_random_request(lim);
            end
        end

        // Release reset after the fixed reset window
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Wait for the last request and its result, then watch for strays
        while (pend_q.size() != 0 || outcome_q.size() != 0 || start)
            @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        if (mismatch_count == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    // Timeout guard
    initial begin
        #(TIMEOUT_NS);
        $display("FAILED: results differ");
        $finish;
    end

endmodule

@@ filelist.f @@
hdl/mbrl_pkg.sv
hdl/mbrl_alu.sv
hdl/mbrl_table.sv
hdl/memory_budget_reservation_ledger.sv
bench/tb.sv
